/* hw/rtl/potb_pkg.sv */
package potb_pkg;

  localparam int NUM_TIMERS_DEF = 16;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_SETUP   = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;
  localparam logic [2:0] CMD_RELEASE = 3'd5;

  // one slot as held in the slot RAM
  typedef struct packed {
    logic [31:0] alarm;
    logic [31:0] interval;
    logic        periodic;
    logic [7:0]  prio;
    logic [1:0]  notify;
  } slot_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMD   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

/* hw/rtl/potb_ram.sv */
module potb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/periodic_one_shot_timer_bank_top.sv */
// Non-tick command: applied in the cycle after it is accepted (slot RAM read, then write back).
// Tick: one slot a cycle through the RAM read port, except while the result channel stalls;
// the tick's last result leaves in its final cycle.
// One item in work at a time; a finished result may still wait in the output register.
// Reset (synchronous, rst_n low) clears the time counter, in-use and running flags and the
// channels; the slot RAM is not cleared, its entries are written by setup before use.
module periodic_one_shot_timer_bank_top #(
  parameter int NUM_TIMERS = potb_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] timer_id, [35:4] interval_ms, [36] auto_reload, [44:37] event_priority,
  // [46:45] notify_mode, [47] zero
  input  logic [47:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] fired_id, [11:4] fired_priority
  output logic [15:0] out_tdata,
  // [0] delivery
  output logic [0:0]  out_tuser,
  output logic        out_tlast
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ENT_W  = $bits(potb_pkg::slot_entry_t);

  potb_pkg::state_t state_r, state_nxt;

  logic [31:0]           now_r, now_nxt;
  logic [NUM_TIMERS-1:0] in_use_r, in_use_nxt;
  logic [NUM_TIMERS-1:0] run_r, run_nxt;
  logic [SLOT_W-1:0]     scan_r, scan_nxt;

  logic [2:0]            cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  id_ok_r, id_ok_nxt;
  logic [31:0]           ival_r, ival_nxt;
  logic                  periodic_r, periodic_nxt;
  logic [7:0]            prio_r, prio_nxt;
  logic [1:0]            notify_r, notify_nxt;

  logic                  pend_valid_r, pend_valid_nxt;
  logic [3:0]            pend_id_r, pend_id_nxt;
  logic [7:0]            pend_prio_r, pend_prio_nxt;
  logic                  pend_dlv_r, pend_dlv_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [3:0]            out_id_r, out_id_nxt;
  logic [7:0]            out_prio_r, out_prio_nxt;
  logic                  out_dlv_r, out_dlv_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [SLOT_W-1:0]     ram_raddr;
  potb_pkg::slot_entry_t ram_wdata;
  potb_pkg::slot_entry_t ram_rdata;
  logic [ENT_W-1:0]      ram_rdata_raw;

  logic [6:0]            in_id_ext;
  logic [6:0]            scan_ext;
  logic [31:0]           arm_alarm;
  logic                  out_free;
  logic                  hit;
  logic                  need_emit;
  logic                  stall;

  potb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = potb_pkg::slot_entry_t'(ram_rdata_raw);

  assign in_id_ext = {3'b000, in_tdata[3:0]};
  assign scan_ext  = 7'(scan_r);
  assign arm_alarm = now_r + ram_rdata.interval;
  assign out_free  = !out_valid_r || out_tready;

  assign hit       = in_use_r[scan_r] && run_r[scan_r] && !(now_r < ram_rdata.alarm);
  assign need_emit = hit && (ram_rdata.notify != 2'b00);
  assign stall     = need_emit && pend_valid_r && !out_free;

  assign in_tready  = (state_r == potb_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_prio_r, out_id_r};
  assign out_tuser  = out_dlv_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    in_use_nxt     = in_use_r;
    run_nxt        = run_r;
    scan_nxt       = scan_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    id_ok_nxt      = id_ok_r;
    ival_nxt       = ival_r;
    periodic_nxt   = periodic_r;
    prio_nxt       = prio_r;
    notify_nxt     = notify_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_prio_nxt  = pend_prio_r;
    pend_dlv_nxt   = pend_dlv_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_dlv_nxt    = out_dlv_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = scan_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = scan_r;

    unique case (state_r)
      potb_pkg::ST_IDLE: begin
        cmd_nxt      = in_tuser;
        slot_nxt     = in_id_ext[SLOT_W-1:0];
        id_ok_nxt    = (in_id_ext < 7'(NUM_TIMERS));
        ival_nxt     = in_tdata[35:4];
        periodic_nxt = in_tdata[36];
        prio_nxt     = in_tdata[44:37];
        notify_nxt   = in_tdata[46:45];
        if (in_tuser == potb_pkg::CMD_TICK) begin
          ram_raddr = '0;
        end else begin
          ram_raddr = in_id_ext[SLOT_W-1:0];
        end
        if (in_tvalid) begin
          if (in_tuser == potb_pkg::CMD_TICK) begin
            now_nxt   = now_r + 32'd1;
            scan_nxt  = '0;
            state_nxt = potb_pkg::ST_SCAN;
          end else begin
            state_nxt = potb_pkg::ST_CMD;
          end
        end
      end

      potb_pkg::ST_CMD: begin
        ram_waddr = slot_r;
        state_nxt = potb_pkg::ST_IDLE;
        if (id_ok_r) begin
          unique case (cmd_r)
            potb_pkg::CMD_SETUP: begin
              in_use_nxt[slot_r]  = 1'b1;
              run_nxt[slot_r]     = 1'b0;
              ram_we              = 1'b1;
              ram_wdata.interval  = ival_r;
              ram_wdata.periodic  = periodic_r;
              ram_wdata.prio      = prio_r;
              ram_wdata.notify    = notify_r;
            end
            potb_pkg::CMD_START: begin
              if (in_use_r[slot_r] && !run_r[slot_r]) begin
                run_nxt[slot_r] = 1'b1;
                ram_we          = 1'b1;
                ram_wdata.alarm = arm_alarm;
              end
            end
            potb_pkg::CMD_STOP: begin
              if (in_use_r[slot_r]) begin
                run_nxt[slot_r] = 1'b0;
              end
            end
            potb_pkg::CMD_RESTART: begin
              if (in_use_r[slot_r]) begin
                run_nxt[slot_r] = 1'b1;
                ram_we          = 1'b1;
                ram_wdata.alarm = arm_alarm;
              end
            end
            potb_pkg::CMD_RELEASE: begin
              if (in_use_r[slot_r]) begin
                run_nxt[slot_r]    = 1'b0;
                in_use_nxt[slot_r] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      potb_pkg::ST_SCAN: begin
        // hold the read address on a stall so the entry stays on the read port
        if (!stall) begin
          if (hit) begin
            if (ram_rdata.periodic) begin
              ram_we          = 1'b1;
              ram_wdata.alarm = arm_alarm;
            end else begin
              run_nxt[scan_r] = 1'b0;
            end
          end
          if (need_emit) begin
            // a newer fire proves the held one is not the last of the tick
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = pend_id_r;
              out_prio_nxt  = pend_prio_r;
              out_dlv_nxt   = pend_dlv_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = scan_ext[3:0];
            pend_prio_nxt  = ram_rdata.prio;
            pend_dlv_nxt   = ram_rdata.notify[1];
          end
          if (scan_r == SLOT_W'(NUM_TIMERS - 1)) begin
            state_nxt = potb_pkg::ST_FLUSH;
          end else begin
            scan_nxt  = scan_r + SLOT_W'(1);
            ram_raddr = scan_r + SLOT_W'(1);
          end
        end
      end

      potb_pkg::ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = potb_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = pend_id_r;
          out_prio_nxt   = pend_prio_r;
          out_dlv_nxt    = pend_dlv_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = potb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = potb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= potb_pkg::ST_IDLE;
      now_r        <= '0;
      in_use_r     <= '0;
      run_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      in_use_r     <= in_use_nxt;
      run_r        <= run_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    cmd_r       <= cmd_nxt;
    slot_r      <= slot_nxt;
    id_ok_r     <= id_ok_nxt;
    ival_r      <= ival_nxt;
    periodic_r  <= periodic_nxt;
    prio_r      <= prio_nxt;
    notify_r    <= notify_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_prio_r <= pend_prio_nxt;
    pend_dlv_r  <= pend_dlv_nxt;
    out_id_r    <= out_id_nxt;
    out_prio_r  <= out_prio_nxt;
    out_dlv_r   <= out_dlv_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

/* verif/periodic_one_shot_timer_bank_top_test.sv */
`timescale 1ns / 100ps

module periodic_one_shot_timer_bank_top_test;

  localparam int NUM_SLOTS = potb_pkg::NUM_TIMERS_DEF;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 450;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;

  // fields of one command item, last field in the lowest bits
  typedef struct packed {
    logic [1:0]  notify;
    logic [7:0]  prio;
    logic        periodic;
    logic [31:0] interval;
    logic [3:0]  id;
  } cmd_fields_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [7:0] prio;
    logic       posted;
    logic       last;
  } fire_t;

  class fire_scoreboard;
    bit [31:0] now_ticks;
    bit        in_use  [NUM_SLOTS];
    bit        running [NUM_SLOTS];
    bit [31:0] alarm   [NUM_SLOTS];
    bit [31:0] period  [NUM_SLOTS];
    bit        reload  [NUM_SLOTS];
    bit [7:0]  prio    [NUM_SLOTS];
    bit [1:0]  notify  [NUM_SLOTS];
    fire_t     pending_fires[$];
    int        mismatches;

    function void apply_command(logic [2:0] cmd, cmd_fields_t f);
      fire_t fr;
      int    fired;
      int    id;
      fired = 0;
      id = int'(f.id);
      if (cmd == potb_pkg::CMD_TICK) begin
        now_ticks = now_ticks + 32'd1;
        // scan in slot order; plain unsigned compare, no wrap handling
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!in_use[s] || !running[s] || now_ticks < alarm[s]) continue;
          if (reload[s]) alarm[s] = now_ticks + period[s];
          else running[s] = 1'b0;
          if (notify[s] != 2'd0) begin
            fr.slot = 4'(s);
            fr.prio = prio[s];
            fr.posted = notify[s][1];
            fr.last = 1'b0;
            pending_fires.push_back(fr);
            fired++;
          end
        end
        if (fired > 0) pending_fires[pending_fires.size() - 1].last = 1'b1;
        return;
      end
      if (id >= NUM_SLOTS) return;
      case (cmd)
        potb_pkg::CMD_SETUP: begin
          in_use[id] = 1'b1;
          running[id] = 1'b0;
          period[id] = f.interval;
          reload[id] = f.periodic;
          prio[id] = f.prio;
          notify[id] = f.notify;
        end
        potb_pkg::CMD_START: begin
          if (in_use[id] && !running[id]) begin
            alarm[id] = now_ticks + period[id];
            running[id] = 1'b1;
          end
        end
        potb_pkg::CMD_STOP: begin
          if (in_use[id]) running[id] = 1'b0;
        end
        potb_pkg::CMD_RESTART: begin
          if (in_use[id]) begin
            alarm[id] = now_ticks + period[id];
            running[id] = 1'b1;
          end
        end
        potb_pkg::CMD_RELEASE: begin
          if (in_use[id]) begin
            running[id] = 1'b0;
            in_use[id] = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_fire(fire_t got);
      fire_t want;
      if (pending_fires.size() == 0) begin
        flag($sformatf("%0t: unexpected fire: slot %0d prio 0x%02h posted %0b last %0b",
                       $time, got.slot, got.prio, got.posted, got.last));
        return;
      end
      want = pending_fires.pop_front();
      if (want.slot !== got.slot || want.prio !== got.prio ||
          want.posted !== got.posted || want.last !== got.last)
        flag($sformatf({"%0t: fire mismatch: expected slot %0d prio 0x%02h posted %0b last %0b,",
                        " got slot %0d prio 0x%02h posted %0b last %0b"},
                       $time, want.slot, want.prio, want.posted, want.last,
                       got.slot, got.prio, got.posted, got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  fire_scoreboard sb;
  bit rx_hold_req;
  bit tx_calm;
  int tx_count;
  int idle_cycles;

  periodic_one_shot_timer_bank_top #(
    .NUM_TIMERS(NUM_SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_fire({out_tdata[3:0], out_tdata[11:4], out_tuser[0], out_tlast});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("periodic_one_shot_timer_bank_top_test failed");
      $finish;
    end
  end

  // result side: short random stalls, rare long ones, calm stretches, one long hold
  initial begin : rx_side
    int gap_left;
    int r;
    int cyc;
    bit calm;
    gap_left = 0;
    cyc = 0;
    calm = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r < 18) gap_left = $urandom_range(1, 3);
          else if (r < 20) gap_left = $urandom_range(15, 50);
        end
      end
      cyc++;
      if (cyc % 300 == 0) calm = ($urandom_range(0, 2) == 0);
    end
  end

  function automatic cmd_fields_t random_fields();
    cmd_fields_t f;
    f.id = 4'($urandom_range(0, NUM_SLOTS - 1));
    f.interval = $urandom();
    f.periodic = 1'($urandom());
    f.prio = 8'($urandom());
    f.notify = 2'($urandom());
    return f;
  endfunction

  // offer one item, hold it until taken, note it, then maybe idle
  task automatic send_cmd(logic [2:0] cmd, cmd_fields_t f);
    int r;
    int gap;
    in_tuser <= cmd;
    in_tdata <= {1'b0, f};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_command(cmd, f);
    tx_count++;
    if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = 0;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r < 50) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= {16'($urandom()), $urandom()};
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic slot_cmd(logic [2:0] cmd, int id);
    cmd_fields_t f;
    f = random_fields();
    f.id = 4'(id);
    send_cmd(cmd, f);
  endtask

  task automatic setup_slot(int id, logic [31:0] interval, logic periodic,
                            logic [7:0] prio, logic [1:0] notify);
    cmd_fields_t f;
    f.id = 4'(id);
    f.interval = interval;
    f.periodic = periodic;
    f.prio = prio;
    f.notify = notify;
    send_cmd(potb_pkg::CMD_SETUP, f);
  endtask

  task automatic wait_for_fires_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_fires.size() != 0) @(posedge clk);
  endtask

  // load up fast periodic slots, hold the result side off and keep ticking
  task automatic stall_receiver_under_load();
    for (int s = 0; s < 6; s++) begin
      setup_slot(s, 32'd0, 1'b1, 8'($urandom()), 2'(1 + s % 3));
      slot_cmd(potb_pkg::CMD_START, s);
    end
    rx_hold_req = 1'b1;
    repeat (12) send_cmd(potb_pkg::CMD_TICK, random_fields());
  endtask

  initial begin : stimulus
    cmd_fields_t f;
    logic [2:0]  cmd;
    int          r;
    bit          stall_done;
    bit          pause_done;
    sb = new();
    stall_done = 1'b0;
    pause_done = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= potb_pkg::CMD_TICK;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // commands on a slot never set up
    slot_cmd(potb_pkg::CMD_STOP, 3);
    slot_cmd(potb_pkg::CMD_START, 3);
    slot_cmd(potb_pkg::CMD_RESTART, 3);
    slot_cmd(potb_pkg::CMD_RELEASE, 3);
    slot_cmd(CMD_SPARE_A, 0);
    slot_cmd(CMD_SPARE_B, 15);
    // zero interval, largest interval, notify mode three, silent one-shot
    setup_slot(0, 32'd0, 1'b1, 8'hFF, 2'd1);
    setup_slot(15, 32'hFFFF_FFFF, 1'b0, 8'h00, 2'd2);
    setup_slot(7, 32'd2, 1'b1, 8'h5A, 2'd3);
    setup_slot(8, 32'd1, 1'b0, 8'hA5, 2'd0);
    slot_cmd(potb_pkg::CMD_START, 0);
    slot_cmd(potb_pkg::CMD_START, 15);
    slot_cmd(potb_pkg::CMD_START, 7);
    slot_cmd(potb_pkg::CMD_START, 8);
    slot_cmd(potb_pkg::CMD_TICK, 0);
    slot_cmd(potb_pkg::CMD_START, 0);
    slot_cmd(potb_pkg::CMD_TICK, 0);
    // alarm wraps past zero and fires on the next tick
    slot_cmd(potb_pkg::CMD_RESTART, 15);
    slot_cmd(potb_pkg::CMD_TICK, 0);
    slot_cmd(potb_pkg::CMD_STOP, 0);
    // setup over a running slot leaves it stopped
    setup_slot(7, 32'd5, 1'b0, 8'h33, 2'd1);
    slot_cmd(potb_pkg::CMD_TICK, 0);
    slot_cmd(potb_pkg::CMD_RELEASE, 15);
    slot_cmd(potb_pkg::CMD_START, 15);
    slot_cmd(potb_pkg::CMD_RESTART, 7);

    while (tx_count < RANDOM_ITEMS) begin
      if (!stall_done && tx_count >= 150) begin
        stall_receiver_under_load();
        stall_done = 1'b1;
      end
      if (!pause_done && tx_count >= 300) begin
        wait_for_fires_drained();
        pause_done = 1'b1;
      end
      f = random_fields();
      r = $urandom_range(0, 99);
      if (r < 36) cmd = potb_pkg::CMD_TICK;
      else if (r < 52) begin
        cmd = potb_pkg::CMD_SETUP;
        r = $urandom_range(0, 99);
        if (r < 60) f.interval = $urandom_range(0, 4);
        else if (r < 85) f.interval = $urandom_range(5, 30);
        else if (r < 95) f.interval = $urandom_range(31, 300);
      end
      else if (r < 70) cmd = potb_pkg::CMD_START;
      else if (r < 80) cmd = potb_pkg::CMD_RESTART;
      else if (r < 90) cmd = potb_pkg::CMD_STOP;
      else if (r < 97) cmd = potb_pkg::CMD_RELEASE;
      else cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
      send_cmd(cmd, f);
    end

    wait_for_fires_drained();
    repeat (NUM_SLOTS + 8) @(posedge clk);
    if (sb.pending_fires.size() != 0)
      $display("%0d fire results never arrived", sb.pending_fires.size());
    if (sb.mismatches == 0 && sb.pending_fires.size() == 0)
      $display("periodic_one_shot_timer_bank_top_test passed");
    else
      $display("periodic_one_shot_timer_bank_top_test failed");
    $finish;
  end

endmodule
